### src/c3wf_pkg.sv
// ----------------------------------------------------------------------------
// c3wf_pkg: shared types and constants of the 3x3 window filter
// Payload structs, filter mode codes, register indexes and window type.
// ----------------------------------------------------------------------------
package c3wf_pkg;

    localparam int PIX_W      = 8;
    localparam int CX_W       = 10;
    localparam int CY_W       = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 12;

    typedef enum logic [2:0] {
        MODE_BOX       = 3'd0,
        MODE_GAUSS     = 3'd1,
        MODE_PREWITT_X = 3'd2,
        MODE_PREWITT_Y = 3'd3,
        MODE_SOBEL_X   = 3'd4,
        MODE_SOBEL_Y   = 3'd5,
        MODE_LAPLACE   = 3'd6,
        MODE_SHARPEN   = 3'd7
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd512;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 12'd512;

    // Window entry r*3+c: row 0 is the oldest row, column 0 the oldest column
    typedef logic [8:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [CX_W-1:0]  center_x;
        logic [CY_W-1:0]  center_y;
        logic             frame_last;
    } t_pix_out;

endpackage

### src/c3wf_stream_if.sv
// ----------------------------------------------------------------------------
// c3wf_stream_if: valid/ready stream channel
// Carries one request payload of type T per accepted handshake.
// ----------------------------------------------------------------------------
interface c3wf_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/c3wf_ram.sv
// ----------------------------------------------------------------------------
// c3wf_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module c3wf_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/c3wf_kernel.sv
// ----------------------------------------------------------------------------
// c3wf_kernel: 3x3 kernel arithmetic
// Computes the selected filter over one window, result in 0..255.
// ----------------------------------------------------------------------------
module c3wf_kernel (
    input  c3wf_pkg::t_mode            i_mode,
    input  c3wf_pkg::t_window          i_win,
    output logic [c3wf_pkg::PIX_W-1:0] o_pixel
);
    import c3wf_pkg::*;

    logic signed [12:0] v [9];
    logic signed [12:0] total;
    logic signed [12:0] gauss;
    logic signed [12:0] prew_x, prew_y, sob_x, sob_y, lapl, sharp;
    logic signed [12:0] prew_sel, sob_sel;
    logic [9:0]         prew_abs, sob_abs;
    logic [11:0]        lapl_abs;
    logic [21:0]        prew_prod;
    logic [24:0]        box_prod;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            v[i] = $signed({5'd0, i_win[i]});
        end
    end

    assign total = v[0] + v[1] + v[2] + v[3] + v[4] + v[5] + v[6] + v[7] + v[8];
    assign gauss = v[0] + (v[1] <<< 1) + v[2] + (v[3] <<< 1) + (v[4] <<< 2)
                 + (v[5] <<< 1) + v[6] + (v[7] <<< 1) + v[8];

    assign prew_x = (v[2] + v[5] + v[8]) - (v[0] + v[3] + v[6]);
    assign prew_y = (v[6] + v[7] + v[8]) - (v[0] + v[1] + v[2]);
    assign sob_x  = (v[2] + (v[5] <<< 1) + v[8]) - (v[0] + (v[3] <<< 1) + v[6]);
    assign sob_y  = (v[6] + (v[7] <<< 1) + v[8]) - (v[0] + (v[1] <<< 1) + v[2]);
    assign lapl   = (v[4] <<< 3) + v[4] - total;
    assign sharp  = (v[4] <<< 3) + (v[4] <<< 1) - total;

    assign prew_sel = (i_mode == MODE_PREWITT_Y) ? prew_y : prew_x;
    assign sob_sel  = (i_mode == MODE_SOBEL_Y) ? sob_y : sob_x;

    // magnitudes: prewitt <= 765, sobel <= 1020, laplace <= 2040
    assign prew_abs = prew_sel[12] ? 10'(-prew_sel) : 10'(prew_sel);
    assign sob_abs  = sob_sel[12] ? 10'(-sob_sel) : 10'(sob_sel);
    assign lapl_abs = lapl[12] ? 12'(-lapl) : 12'(lapl);

    // divide by 3 as *683 >> 11, exact for values up to 765
    assign prew_prod = 22'(prew_abs) * 22'd683;
    // 7281/65536 approximates 1/9 the same way the float 0.11111 truncates
    assign box_prod  = 25'(total) * 25'd7281;

    always_comb begin
        unique case (i_mode)
            MODE_BOX:       o_pixel = box_prod[23:16];
            MODE_GAUSS:     o_pixel = gauss[11:4];
            MODE_PREWITT_X,
            MODE_PREWITT_Y: o_pixel = prew_prod[18:11];
            MODE_SOBEL_X,
            MODE_SOBEL_Y:   o_pixel = sob_abs[9:2];
            MODE_LAPLACE:   o_pixel = lapl_abs[10:3];
            MODE_SHARPEN: begin
                if (sharp[12]) begin
                    o_pixel = '0;
                end else if (sharp > 13'sd255) begin
                    o_pixel = '1;
                end else begin
                    o_pixel = sharp[7:0];
                end
            end
            default:        o_pixel = '0;
        endcase
    end

endmodule

### src/conv3x3_window_filter_unit.sv
// ----------------------------------------------------------------------------
// conv3x3_window_filter_unit: streaming 3x3 convolution filter
// Raster-order grey pixels in, one filtered pixel out per interior centre.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while the output is not stalled, set by the
//   single line buffer RAM port pair. An accepted pixel passes the line buffer
//   read, the window register and the output register before its result is on o_res.
// Output stalls hold the whole pipeline; border pixels give no result.
// Reset (i_rst_n low, synchronous): counters, window and config return to
//   defaults; line buffer contents are left as they are.
module conv3x3_window_filter_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [c3wf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [c3wf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    c3wf_stream_if.sink                         i_pix,
    c3wf_stream_if.source                       o_res
);
    import c3wf_pkg::*;

    localparam int          COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [12:0] MAX_W = 13'(MAX_WIDTH);

    // configuration
    t_mode              r_mode;
    logic [IMG_W_W-1:0] r_img_w;
    logic [IMG_H_W-1:0] r_img_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BOX;
            r_img_w <= IMAGE_WIDTH_RST;
            r_img_h <= IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FILTER_MODE:  r_mode  <= t_mode'(i_cfg_data[2:0]);
                REG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline enable: everything moves unless a result sits untaken
    logic r_out_valid;
    logic en;
    logic accept;

    assign en          = !r_out_valid || o_res.ready;
    assign i_pix.ready = en;
    assign accept      = i_pix.valid && en;

    // raster position
    logic [COL_W-1:0] r_col;
    logic [CY_W-1:0]  r_row;
    logic [12:0]      w_in, w_eff, col_ext;
    logic [IMG_H_W-1:0] h_eff;
    logic             row_end, frame_end, emit;

    assign w_in    = 13'(r_img_w);
    assign w_eff   = (w_in < 13'd3) ? 13'd3 : ((w_in > MAX_W) ? MAX_W : w_in);
    assign h_eff   = (r_img_h < 12'd3) ? 12'd3 : r_img_h;
    assign col_ext = 13'(r_col);
    assign row_end   = col_ext >= (w_eff - 13'd1);
    assign frame_end = row_end && (r_row >= (h_eff - 12'd1));
    assign emit      = (col_ext >= 13'd2) && (r_row >= 12'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // stage A: line buffer read in flight
    logic             r_a_valid;
    logic             r_a_emit;
    logic             r_a_last;
    logic [COL_W-1:0] r_a_addr;
    logic [PIX_W-1:0] r_a_pix;
    logic [CX_W-1:0]  r_a_cx;
    logic [CY_W-1:0]  r_a_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_emit <= emit;
            r_a_last <= frame_end;
            r_a_addr <= r_col;
            r_a_pix  <= i_pix.data.pixel_in;
            r_a_cx   <= CX_W'(col_ext - 13'd1);
            r_a_cy   <= r_row - 1'b1;
        end
    end

    // both line buffers in one RAM: upper in the high byte, middle in the low
    logic [2*PIX_W-1:0] lb_rdata;
    logic [PIX_W-1:0]   lb_up, lb_mid;
    logic               lb_we;

    assign lb_up  = lb_rdata[2*PIX_W-1:PIX_W];
    assign lb_mid = lb_rdata[PIX_W-1:0];
    assign lb_we  = en && r_a_valid;

    c3wf_ram #(
        .WIDTH  (2 * PIX_W),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (r_a_addr),
        .i_wdata ({lb_mid, r_a_pix}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (lb_rdata)
    );

    // stage B: window register
    t_window          r_win;
    t_window          n_win;
    logic             r_b_valid;
    logic             r_b_last;
    logic [CX_W-1:0]  r_b_cx;
    logic [CY_W-1:0]  r_b_cy;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3 + 1];
            n_win[r*3 + 1] = r_win[r*3 + 2];
        end
        n_win[2] = lb_up;
        n_win[5] = lb_mid;
        n_win[8] = r_a_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid && r_a_emit;
            if (r_a_valid) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_last <= r_a_last;
            r_b_cx   <= r_a_cx;
            r_b_cy   <= r_a_cy;
        end
    end

    // stage C: filter and output register
    logic [PIX_W-1:0] kern_pix;
    t_pix_out         r_out;

    c3wf_kernel u_kernel (
        .i_mode  (r_mode),
        .i_win   (r_win),
        .o_pixel (kern_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.pixel_out  <= kern_pix;
            r_out.center_x   <= r_b_cx;
            r_out.center_y   <= r_b_cy;
            r_out.frame_last <= r_b_last;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // checks
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && frame_end |=> (r_col == '0) && (r_row == '0))
        else $error("counters did not wrap at frame end");

    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !row_end |=> (r_col == $past(r_col) + 1'b1) && $stable(r_row))
        else $error("column counter did not advance");

    a_stall_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_win) && $stable(r_a_valid) && $stable(r_b_valid))
        else $error("pipeline moved during output stall");

    a_no_lb_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lb_we |-> r_a_valid && en)
        else $error("line buffer written without a request in stage A");

endmodule

### tb/conv3x3_window_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// conv3x3_window_filter_unit_tb: self-checking bench for the 3x3 window filter
// Streams raster frames through the unit under random valid/ready gaps and
// checks every filtered pixel, its centre coordinates and the frame-end flag
// against a cycle-free model of line buffers, window and counters.
// ----------------------------------------------------------------------------
module conv3x3_window_filter_unit_tb;
    import c3wf_pkg::*;

    localparam int LB_DEPTH    = 1024;
    localparam int RANDOM_PX   = 880;
    localparam int LATENCY_PAD = 4;
    localparam int LONG_HOLD   = 300;
    // about 2000 pixels; even with handshake idling, the long stall and config
    // gaps this stays far below the limit
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int STYLE_NOISE  = 0;
    localparam int STYLE_BINARY = 1;
    localparam int STYLE_RAMP   = 2;
    localparam int STYLE_BARS   = 3;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    c3wf_stream_if #(.T(t_pix_in))  pix_if ();
    c3wf_stream_if #(.T(t_pix_out)) res_if ();

    conv3x3_window_filter_unit #(
        .MAX_WIDTH(LB_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if.sink),
        .o_res      (res_if.source)
    );

    // filter state as the stream sees it
    logic [PIX_W-1:0]   lb_upper [LB_DEPTH];
    logic [PIX_W-1:0]   lb_middle [LB_DEPTH];
    t_window            win      = '0;
    int                 col_cnt  = 0;
    int                 row_cnt  = 0;
    t_mode              cfg_mode = MODE_BOX;
    logic [IMG_W_W-1:0] cfg_w    = IMAGE_WIDTH_RST;
    logic [IMG_H_W-1:0] cfg_h    = IMAGE_HEIGHT_RST;

    logic [PIX_W-1:0] pix_q [$];
    t_pix_out         filtered_q [$];

    int   send_idle_pct = 18;
    int   recv_idle_pct = 49;
    int   pushed_cnt    = 0;
    int   px_cnt        = 0;
    int   res_cnt       = 0;
    int   err_cnt       = 0;
    int   frame_cnt     = 0;
    int   cycle_cnt     = 0;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int eff_width();
        int w;
        w = int'(cfg_w);
        if (w < 3) w = 3;
        if (w > LB_DEPTH) w = LB_DEPTH;
        return w;
    endfunction

    function automatic int eff_height();
        return (int'(cfg_h) < 3) ? 3 : int'(cfg_h);
    endfunction

    function automatic int mag(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [PIX_W-1:0] filter_value(t_window wv, t_mode m);
        int p [9];
        int total;
        int s;
        total = 0;
        for (int i = 0; i < 9; i++) begin
            p[i] = int'(wv[i]);
            total += p[i];
        end
        case (m)
            MODE_BOX:       s = (total * 7281) >>> 16;
            MODE_GAUSS:     s = (p[0] + 2*p[1] + p[2] + 2*p[3] + 4*p[4] + 2*p[5]
                                 + p[6] + 2*p[7] + p[8]) >>> 4;
            MODE_PREWITT_X: s = mag((p[2] + p[5] + p[8]) - (p[0] + p[3] + p[6])) / 3;
            MODE_PREWITT_Y: s = mag((p[6] + p[7] + p[8]) - (p[0] + p[1] + p[2])) / 3;
            MODE_SOBEL_X:   s = mag((p[2] + 2*p[5] + p[8]) - (p[0] + 2*p[3] + p[6])) / 4;
            MODE_SOBEL_Y:   s = mag((p[6] + 2*p[7] + p[8]) - (p[0] + 2*p[1] + p[2])) / 4;
            MODE_LAPLACE:   s = mag(9 * p[4] - total) / 8;
            MODE_SHARPEN: begin
                s = 10 * p[4] - total;
                if (s < 0) s = 0;
                if (s > 255) s = 255;
            end
            default:        s = 0;
        endcase
        return s[PIX_W-1:0];
    endfunction

    // one accepted pixel: shift the window, update line buffers and counters
    task automatic advance_window(logic [PIX_W-1:0] p);
        int               w;
        int               h;
        int               x;
        int               y;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        bit               row_end;
        bit               frame_end;
        t_pix_out         r;
        w = eff_width();
        h = eff_height();
        x = col_cnt;
        y = row_cnt;
        up  = lb_upper[x % LB_DEPTH];
        mid = lb_middle[x % LB_DEPTH];
        row_end   = (x >= w - 1);
        frame_end = row_end && (y >= h - 1);
        for (int k = 0; k < 3; k++) begin
            win[k*3]     = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = p;
        lb_upper[x % LB_DEPTH]  = mid;
        lb_middle[x % LB_DEPTH] = p;
        if (x >= 2 && y >= 2) begin
            r.pixel_out  = filter_value(win, cfg_mode);
            r.center_x   = CX_W'(x - 1);
            r.center_y   = CY_W'(y - 1);
            r.frame_last = frame_end;
            filtered_q.push_back(r);
        end
        if (frame_end) begin
            col_cnt = 0;
            row_cnt = 0;
        end else if (row_end) begin
            col_cnt = 0;
            row_cnt = (y + 1) % 4096;
        end else begin
            col_cnt = x + 1;
        end
    endtask

    task automatic check_result(t_pix_out got);
        t_pix_out want;
        res_cnt++;
        if (filtered_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("ERROR: unexpected result pix=%0d x=%0d y=%0d last=%0b",
                         got.pixel_out, got.center_x, got.center_y, got.frame_last);
        end else begin
            want = filtered_q.pop_front();
            if (got.pixel_out !== want.pixel_out || got.center_x !== want.center_x ||
                got.center_y !== want.center_y || got.frame_last !== want.frame_last) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS) begin
                    $display("ERROR: result %0d exp pix=%0d x=%0d y=%0d last=%0b",
                             res_cnt, want.pixel_out, want.center_x, want.center_y,
                             want.frame_last);
                    $display("       got pix=%0d x=%0d y=%0d last=%0b",
                             got.pixel_out, got.center_x, got.center_y, got.frame_last);
                end
            end
        end
    endtask

    // sender: keeps a request up until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                advance_window(pix_if.data.pixel_in);
                px_cnt++;
            end
            if (!pix_if.valid || pix_if.ready) begin
                if (pix_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    pix_if.valid         <= 1'b1;
                    pix_if.data.pixel_in <= pix_q.pop_front();
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready)
                check_result(res_if.data);
            res_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // one long output stall so the pipeline backs up into the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, filtered_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FILTER_MODE:  cfg_mode = t_mode'(data[2:0]);
            REG_IMAGE_WIDTH:  cfg_w    = data[IMG_W_W-1:0];
            REG_IMAGE_HEIGHT: cfg_h    = data[IMG_H_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // wait until every request is taken and every result is back
    task automatic drain();
        while (px_cnt != pushed_cnt || filtered_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic queue_pixel(logic [PIX_W-1:0] p);
        pix_q.push_back(p);
        pushed_cnt++;
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(int style, int r, int c);
        case (style)
            STYLE_NOISE:  return PIX_W'($urandom_range(0, 255));
            STYLE_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            STYLE_RAMP:   return PIX_W'(r * 9 + c * 5 + $urandom_range(0, 3));
            default:      return (((c >> 1) + (r >> 1)) % 2 == 1) ?
                                 PIX_W'(255 - $urandom_range(0, 3)) :
                                 PIX_W'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic push_rows(int rows, int style);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < eff_width(); c++)
                queue_pixel(make_pixel(style, r, c));
    endtask

    task automatic set_idling(int progress);
        if (progress < 100) begin
            send_idle_pct = 18;
            recv_idle_pct = 49;
        end else if (progress < 500) begin
            send_idle_pct = 49;
            recv_idle_pct = 18;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    initial begin
        int                    random_px;
        int                    style;
        int                    r;
        int                    c;
        bit                    pressure_now;
        bit                    pressure_sent;
        t_mode                 m;
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;

        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        res_if.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 4x6 frame, a new filter mode before every pixel that completes a window
        cfg_write(REG_UNUSED, 12'hABC);
        cfg_write(REG_IMAGE_WIDTH, 12'd4);
        cfg_write(REG_IMAGE_HEIGHT, 12'd6);
        m = MODE_BOX;
        for (int k = 0; k < 24; k++) begin
            r = k / 4;
            c = k % 4;
            if (r >= 2 && c >= 2) begin
                drain();
                cfg_write(REG_FILTER_MODE, {9'(k * 37), m});
                m = t_mode'(int'(m) + 1);
            end
            // vertical edge first, then a 0/255 checkerboard
            queue_pixel((r < 3) ? ((c >= 2) ? 8'hFF : 8'h00) :
                        (((r + c) % 2 == 1) ? 8'hFF : 8'h00));
        end
        frame_cnt++;

        // tallest height, cut short mid-frame by a height below the minimum
        drain();
        cfg_write(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 7)));
        cfg_write(REG_IMAGE_WIDTH, 12'd0);
        cfg_write(REG_IMAGE_HEIGHT, 12'hFFF);
        push_rows(5, STYLE_NOISE);
        drain();
        cfg_write(REG_IMAGE_HEIGHT, 12'd0);
        push_rows(1, STYLE_BINARY);
        frame_cnt++;

        // widest row (register overflows and clamps), then narrowed to the minimum
        drain();
        cfg_write(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 7)));
        cfg_write(REG_IMAGE_WIDTH, 12'hFFF);
        cfg_write(REG_IMAGE_HEIGHT, 12'd3);
        push_rows(1, STYLE_RAMP);
        drain();
        cfg_write(REG_IMAGE_WIDTH, 12'd1);
        push_rows(2, STYLE_BARS);
        frame_cnt++;

        random_px     = 0;
        pressure_sent = 1'b0;
        while (random_px < RANDOM_PX) begin
            set_idling(random_px);
            drain();
            pressure_now = !pressure_sent && random_px >= 300;
            if (pressure_now) begin
                cfg_write(REG_IMAGE_WIDTH, 12'd24);
                cfg_write(REG_IMAGE_HEIGHT, 12'd5);
            end else if ($urandom_range(0, 3) != 0) begin
                m = t_mode'($urandom_range(0, 7));
                cfg_write(REG_FILTER_MODE, {9'($urandom), m});
                case ($urandom_range(0, 9))
                    0:       wd = CFG_DATA_W'($urandom_range(0, 2));
                    1:       wd = CFG_DATA_W'($urandom_range(20, 40));
                    default: wd = CFG_DATA_W'($urandom_range(3, 12));
                endcase
                // bit 11 lies above the width register and must be dropped
                wd[11] = 1'($urandom_range(0, 1));
                hd = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 2)) :
                                                   CFG_DATA_W'($urandom_range(3, 7));
                cfg_write(REG_IMAGE_WIDTH, wd);
                cfg_write(REG_IMAGE_HEIGHT, hd);
                if ($urandom_range(0, 7) == 0)
                    cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
            end
            style = $urandom_range(STYLE_NOISE, STYLE_BARS);
            repeat ($urandom_range(1, 2)) begin
                push_rows(eff_height(), style);
                random_px += eff_width() * eff_height();
                frame_cnt++;
            end
            if (pressure_now) begin
                hold_req      <= 1'b1;
                pressure_sent  = 1'b1;
            end
        end

        drain();
        $display("Checked %0d filtered pixels from %0d frames (%0d pixels in), all eight modes",
                 res_cnt, frame_cnt, px_cnt);
        $display("Included clamped widths and heights, mid-frame resizing and a %0d-cycle stall",
                 LONG_HOLD);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
